// ===== hdl/tile_coding_q_engine_assert.svh =====
// ---------------------------------------------------------------------------
// tile_coding_q_engine_assert.svh
// assertion macros for the tile coding value engine
// ---------------------------------------------------------------------------
`ifndef TILE_CODING_Q_ENGINE_ASSERT_SVH
`define TILE_CODING_Q_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("tcq check failed");
`define TCQ_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("tcq reset check failed");
`else
`define TCQ_ASSERT(lbl, clk, rst_n, prop)
`define TCQ_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== hdl/tcq_pkg.sv =====
// ---------------------------------------------------------------------------
// tcq_pkg
// shared types, codes and helpers of the tile coding value engine
// ---------------------------------------------------------------------------
package tcq_pkg;

    localparam int DEF_DIMS          = 4;
    localparam int DEF_TILINGS       = 8;
    localparam int DEF_ACTIONS       = 4;
    localparam int DEF_MAX_DIVISIONS = 7;

    // accumulator wide enough for sixteen tilings of 32-bit weights
    localparam int ACC_W = 40;

    // register indexes: divisions at 0..3, cell sizes from here on
    localparam logic [2:0] REG_CELL_BASE = 3'd4;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_VALUE  = 2'd1,
        CMD_ALL    = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HI,
        S_CLIP,
        S_DIV,
        S_RD,
        S_ACC,
        S_OUT
    } t_state;

    function automatic logic signed [31:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff});
        lo = $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hdl/tcq_cmd_if.sv =====
// ---------------------------------------------------------------------------
// tcq_cmd_if
// command item channel of the tile coding value engine
// ---------------------------------------------------------------------------
interface tcq_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] pos_d0;
    logic signed [31:0] pos_d1;
    logic signed [31:0] pos_d2;
    logic signed [31:0] pos_d3;
    logic [1:0]         action;
    logic signed [31:0] weight_change;
    logic [2:0]         tiling_sel;
    logic [1:0]         dim_sel;
    logic [30:0]        offset_value;

    modport source (output valid, cmd, pos_d0, pos_d1, pos_d2, pos_d3, action,
                    weight_change, tiling_sel, dim_sel, offset_value, input ready);
    modport sink (input valid, cmd, pos_d0, pos_d1, pos_d2, pos_d3, action,
                  weight_change, tiling_sel, dim_sel, offset_value, output ready);
endinterface

// ===== hdl/tcq_res_if.sv =====
// ---------------------------------------------------------------------------
// tcq_res_if
// result item channel of the tile coding value engine
// ---------------------------------------------------------------------------
interface tcq_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] q_value;
    logic [1:0]         action_out;
    logic               last;

    modport source (output valid, q_value, action_out, last, input ready);
    modport sink (input valid, q_value, action_out, last, output ready);
endinterface

// ===== hdl/tcq_ram.sv =====
// ---------------------------------------------------------------------------
// tcq_ram
// single port ram with registered read
// ---------------------------------------------------------------------------
module tcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/tile_coding_q_engine.sv =====
// ---------------------------------------------------------------------------
// tile_coding_q_engine
// tile coded action value engine with one shared subtract/compare unit
// ---------------------------------------------------------------------------
// usage
//   i_cmd_if carries one command item: load offset, value of one action,
//   values of all actions, or weight update. o_res_if returns q_value items;
//   last marks the final item of a query. the config port writes divisions
//   (index 0..3) and cell sizes (index 4..7); the user must write only while
//   the engine is idle; the engine itself does not enforce this.
// sequence
//   one item at a time; ready is high only when idle. each tiling and used
//   dimension passes S_HI, S_CLIP and S_DIV, where the shared subtract/compare
//   unit makes the cell steps (at most divisions steps); an ignored dimension
//   passes S_HI alone. then each reported action reads the weight of every
//   tiling through the weight ram port in S_RD and S_ACC and is sent in S_OUT.
//   an update follows a single query but writes back in S_ACC and skips S_OUT.
// reset
//   synchronous, active low. afterwards the weight ram is swept to zero,
//   one entry per cycle, all TILINGS*(MAX_DIVISIONS+1)^4*ACTIONS entries
//   (131072 by default); commands are not taken during the sweep.
// stall
//   a waiting result holds the engine; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "tile_coding_q_engine_assert.svh"

module tile_coding_q_engine #(
    parameter int DIMS          = tcq_pkg::DEF_DIMS,
    parameter int TILINGS       = tcq_pkg::DEF_TILINGS,
    parameter int ACTIONS       = tcq_pkg::DEF_ACTIONS,
    parameter int MAX_DIVISIONS = tcq_pkg::DEF_MAX_DIVISIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcq_cmd_if.sink     i_cmd_if,
    tcq_res_if.source   o_res_if,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import tcq_pkg::*;

    localparam int STRIDE   = MAX_DIVISIONS + 1;
    localparam int CW       = $clog2(STRIDE);
    localparam int FEATS    = STRIDE * STRIDE * STRIDE * STRIDE;
    localparam int FW       = $clog2(TILINGS * FEATS);
    localparam int DEPTH    = TILINGS * FEATS * ACTIONS;
    localparam int AW       = $clog2(DEPTH);
    localparam int TW       = (TILINGS > 1) ? $clog2(TILINGS) : 1;
    localparam int NOFF     = TILINGS * DIMS;
    localparam int OW       = (NOFF > 1) ? $clog2(NOFF) : 1;
    localparam int BW       = 31 + CW;
    localparam int NOUT     = (ACTIONS > 4) ? 4 : ACTIONS;
    localparam logic [1:0] LAST_ACT = 2'(NOUT - 1);

    // state and item registers
    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic signed [31:0] r_pos [4];
    logic [1:0]         r_act;
    logic signed [31:0] r_wchg;
    logic [2:0]         r_divisions [4];
    logic [30:0]        r_cell_size [4];
    logic [30:0]        r_offsets [NOFF];

    // sequencer registers
    logic [TW-1:0]        r_t;
    logic [1:0]           r_d;
    logic [FW-1:0]        r_feat;
    logic [FW-1:0]        r_feats [TILINGS];
    logic [BW-1:0]        r_bound;
    logic [BW:0]          r_rem;
    logic [CW-1:0]        r_q;
    logic [1:0]           r_cur_act;
    logic signed [ACC_W-1:0] r_acc;
    logic [AW-1:0]        r_clr;

    // result registers
    logic signed [31:0] r_q_value;
    logic [1:0]         r_action_out;
    logic               r_last;

    // ram port
    logic           w_we;
    logic [AW-1:0]  w_addr;
    logic [31:0]    w_wdata;
    logic [31:0]    w_rdata;

    // combinational helpers
    logic [CW-1:0]      w_div_eff;
    logic [30:0]        w_cell_eff;
    logic               w_skip;
    logic [1:0]         w_d_idx;
    logic [30:0]        w_off;
    logic signed [31:0] w_p;
    logic [BW-1:0]      w_pc;
    logic [BW:0]        w_s;
    logic               w_step;
    logic [CW-1:0]      w_coord;
    logic [FW-1:0]      w_feat_next;
    logic signed [ACC_W-1:0] w_wext;
    logic signed [ACC_W-1:0] w_acc_next;
    logic signed [31:0] w_upd;
    logic               w_accept;
    logic               w_act_ok;

    assign w_accept = i_cmd_if.valid && i_cmd_if.ready;
    assign w_act_ok = int'(i_cmd_if.action) < ACTIONS;

    // effective divisions and cell size of the current dimension
    always_comb begin
        logic [2:0] v;
        v = r_divisions[r_d];
        if (v == 3'd0) begin
            w_div_eff = CW'(1);
        end else if (int'(v) > MAX_DIVISIONS) begin
            w_div_eff = CW'(MAX_DIVISIONS);
        end else begin
            w_div_eff = CW'(v);
        end
        w_cell_eff = (r_cell_size[r_d] == 31'd0) ? 31'd1 : r_cell_size[r_d];
    end

    assign w_skip  = (int'(r_d) >= DIMS) || (w_div_eff <= CW'(1));
    assign w_d_idx = (int'(r_d) < DIMS) ? r_d : 2'd0;
    assign w_off   = r_offsets[OW'(int'(r_t) * DIMS + int'(w_d_idx))];
    assign w_p     = r_pos[r_d];

    // clip to [0, bound], add tiling offset
    always_comb begin
        if (w_p[31]) begin
            w_pc = '0;
        end else if ({{(BW-31){1'b0}}, w_p[30:0]} > r_bound) begin
            w_pc = r_bound;
        end else begin
            w_pc = {{(BW-31){1'b0}}, w_p[30:0]};
        end
        w_s = {1'b0, w_pc} + (BW+1)'(w_off);
    end

    // shared subtract/compare unit: one cell step per cycle
    assign w_step  = (r_q < w_div_eff) && (r_rem >= (BW+1)'(w_cell_eff));
    assign w_coord = (r_state == S_DIV) ? r_q : '0;
    assign w_feat_next = FW'(int'(r_feat) * STRIDE + int'(w_coord));

    // weight accumulate and saturated update
    assign w_wext     = {{(ACC_W-32){w_rdata[31]}}, w_rdata};
    assign w_acc_next = r_acc + w_wext;
    assign w_upd      = sat_q(w_wext + {{(ACC_W-32){r_wchg[31]}}, r_wchg});

    // ram address: clearing sweep or feature times actions plus action
    always_comb begin
        if (r_state == S_CLR) begin
            w_addr  = r_clr;
            w_we    = 1'b1;
            w_wdata = '0;
        end else begin
            w_addr  = AW'(int'(r_feats[r_t]) * ACTIONS + int'(r_cur_act));
            w_we    = (r_state == S_ACC) && (r_cmd == CMD_UPDATE);
            w_wdata = w_upd;
        end
    end

    tcq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_cmd'(i_cmd_if.cmd))
                        CMD_LOAD:   n_state = S_IDLE;
                        CMD_VALUE:  n_state = w_act_ok ? S_HI : S_OUT;
                        CMD_ALL:    n_state = S_HI;
                        CMD_UPDATE: n_state = w_act_ok ? S_HI : S_IDLE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_HI, S_DIV: begin
                if ((r_state == S_HI && !w_skip) ) begin
                    n_state = S_CLIP;
                end else if (r_state == S_DIV && w_step) begin
                    n_state = S_DIV;
                end else if (r_d == 2'd3 && int'(r_t) == TILINGS - 1) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_HI;
                end
            end
            S_CLIP: n_state = S_DIV;
            S_RD:   n_state = S_ACC;
            S_ACC: begin
                if (int'(r_t) != TILINGS - 1) begin
                    n_state = S_RD;
                end else if (r_cmd == CMD_UPDATE) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_res_if.ready) begin
                    n_state = (r_cmd == CMD_ALL && r_cur_act != LAST_ACT) ? S_RD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers and tiling offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_divisions[i] <= 3'd1;
                r_cell_size[i] <= 31'd65536;
            end
            for (int i = 0; i < NOFF; i++) begin
                r_offsets[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < REG_CELL_BASE) begin
                    r_divisions[i_cfg_idx[1:0]] <= i_cfg_data[2:0];
                end else begin
                    r_cell_size[i_cfg_idx[1:0]] <= i_cfg_data;
                end
            end
            if (w_accept && t_cmd'(i_cmd_if.cmd) == CMD_LOAD
                && int'(i_cmd_if.tiling_sel) < TILINGS && int'(i_cmd_if.dim_sel) < DIMS) begin
                r_offsets[OW'(int'(i_cmd_if.tiling_sel) * DIMS + int'(i_cmd_if.dim_sel))]
                    <= i_cmd_if.offset_value;
            end
        end
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd     <= t_cmd'(i_cmd_if.cmd);
                    r_pos[0]  <= i_cmd_if.pos_d0;
                    r_pos[1]  <= i_cmd_if.pos_d1;
                    r_pos[2]  <= i_cmd_if.pos_d2;
                    r_pos[3]  <= i_cmd_if.pos_d3;
                    r_act     <= i_cmd_if.action;
                    r_wchg    <= i_cmd_if.weight_change;
                    r_t       <= '0;
                    r_d       <= 2'd0;
                    r_feat    <= '0;
                    // out of range single query answers zero at once
                    r_q_value    <= '0;
                    r_action_out <= i_cmd_if.action;
                    r_last       <= 1'b1;
                end
            end
            S_HI, S_DIV: begin
                if (r_state == S_HI && !w_skip) begin
                    r_bound <= BW'(w_cell_eff) * BW'(w_div_eff);
                end else if (r_state == S_DIV && w_step) begin
                    r_rem <= r_rem - (BW+1)'(w_cell_eff);
                    r_q   <= r_q + CW'(1);
                end else if (r_d == 2'd3) begin
                    // coordinate done for the last dimension of this tiling
                    r_feats[r_t] <= w_feat_next;
                    r_d          <= 2'd0;
                    if (int'(r_t) == TILINGS - 1) begin
                        r_t       <= '0;
                        r_acc     <= '0;
                        r_cur_act <= (r_cmd == CMD_ALL) ? 2'd0 : r_act;
                    end else begin
                        r_t    <= r_t + TW'(1);
                        r_feat <= FW'(int'(r_t) + 1);
                    end
                end else begin
                    r_feat <= w_feat_next;
                    r_d    <= r_d + 2'd1;
                end
            end
            S_CLIP: begin
                r_rem <= (w_s == '0) ? '0 : w_s - (BW+1)'(1);
                r_q   <= '0;
            end
            S_ACC: begin
                r_acc <= w_acc_next;
                if (int'(r_t) == TILINGS - 1) begin
                    r_t          <= '0;
                    r_q_value    <= sat_q(w_acc_next);
                    r_action_out <= r_cur_act;
                    r_last       <= (r_cmd != CMD_ALL) || (r_cur_act == LAST_ACT);
                end else begin
                    r_t <= r_t + TW'(1);
                end
            end
            S_OUT: begin
                if (o_res_if.ready) begin
                    r_cur_act <= r_cur_act + 2'd1;
                    r_acc     <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_cmd_if.ready      = (r_state == S_IDLE);
    assign o_res_if.valid      = (r_state == S_OUT);
    assign o_res_if.q_value    = r_q_value;
    assign o_res_if.action_out = r_action_out;
    assign o_res_if.last       = r_last;

    // checks
    `TCQ_ASSERT_RST(a_sweep_after_reset, i_clk, !i_rst_n |=> r_state == S_CLR)
    `TCQ_ASSERT(a_sweep_runs, i_clk, i_rst_n, (r_state == S_CLR && r_clr != AW'(DEPTH - 1)) |=> r_state == S_CLR)
    `TCQ_ASSERT(a_write_source, i_clk, i_rst_n, w_we |-> (r_state == S_CLR || r_cmd == CMD_UPDATE))
    `TCQ_ASSERT(a_coord_bound, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_q <= w_div_eff))

endmodule
